[rtl/core/bgdl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgdl_pkg
// Shared constants and types for the GRBG demosaic and luma block.
// ----------------------------------------------------------------------------
package bgdl_pkg;

  localparam int PIX_W         = 8;
  localparam int FW_W          = 10;
  localparam int FH_W          = 12;
  localparam int ROW_W         = 12;
  localparam int CFG_W         = 12;
  localparam int DEF_MAX_WIDTH = 512;
  localparam int MIN_DIM       = 3;

  localparam logic [FW_W-1:0] FW_RESET = 10'd512;
  localparam logic [FH_W-1:0] FH_RESET = 12'd512;

  // BT.709 weights in Q0.16, sum is 65536
  localparam logic [15:0] LUMA_R = 16'd13933;
  localparam logic [15:0] LUMA_G = 16'd46871;
  localparam logic [15:0] LUMA_B = 16'd4732;

  typedef enum logic [0:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef logic [PIX_W-1:0] pix_t;

endpackage

[rtl/core/bayer_grbg_demosaic_luma.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bayer_grbg_demosaic_luma
// Bilinear GRBG demosaic with BT.709 luma, one raw pixel per beat.
// ----------------------------------------------------------------------------
// Channel | Dir | Beat contents
// in_     | in  | tdata[7:0] raw_pixel
// out_    | out | tdata: blue, green, red, grey, column, row; tlast frame_end
// cfg_    | in  | we / index / wdata, no wait states
//
// One pixel per clock while out_ is not stalled; four register stages from in_ to out_:
// line-memory read, 3x3 window shift, color select, luma multiply-add.
// The line memory is one read and one write port, one entry per column.
// Reset (rst_n low, synchronous) empties the pipeline and zeroes counters;
// the line memory is not cleared. A stalled out_ fills the stages, then
// in_tready drops; border pixels leave no beat.
// ----------------------------------------------------------------------------
module bayer_grbg_demosaic_luma #(
  parameter int MAX_WIDTH = bgdl_pkg::DEF_MAX_WIDTH,
  parameter int CW        = $clog2(MAX_WIDTH),
  parameter int OUT_TW    = ((4 * bgdl_pkg::PIX_W + CW + bgdl_pkg::ROW_W + 7) / 8) * 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // cfg
  input  logic                      cfg_we,
  input  bgdl_pkg::cfg_idx_t        cfg_index,
  input  logic [bgdl_pkg::CFG_W-1:0] cfg_wdata,
  // in
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [7:0]                in_tdata,   // [7:0] raw_pixel
  // out
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [OUT_TW-1:0]         out_tdata,  // blue, green, red, grey, column, row
  output logic                      out_tlast
);

  import bgdl_pkg::*;

  localparam int WCW    = (CW + 1 > FW_W) ? CW + 1 : FW_W;
  localparam int OFF_CL = 4 * PIX_W;
  localparam int OFF_RW = OFF_CL + CW;

  // ---------------- configuration ----------------
  logic [FW_W-1:0] fwidth_r;
  logic [FH_W-1:0] fheight_r;
  logic [WCW-1:0]  eff_w;
  logic [FH_W-1:0] eff_h;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwidth_r  <= FW_RESET;
      fheight_r <= FH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  fwidth_r  <= cfg_wdata[FW_W-1:0];
        CFG_FRAME_HEIGHT: fheight_r <= cfg_wdata[FH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    eff_w = WCW'(fwidth_r);
    if (eff_w > WCW'(MAX_WIDTH)) eff_w = WCW'(MAX_WIDTH);
    if (eff_w < WCW'(MIN_DIM))   eff_w = WCW'(MIN_DIM);
    eff_h = fheight_r;
    if (eff_h < FH_W'(MIN_DIM))  eff_h = FH_W'(MIN_DIM);
  end

  // ---------------- handshake chain ----------------
  logic s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r;
  logic o_free, s3_free, s2_free, s1_free;
  logic s3_go, s2_go, s1_go, in_acc;

  assign o_free  = !out_valid_r || out_tready;
  assign s3_go   = s3_valid_r && o_free;
  assign s3_free = !s3_valid_r || o_free;
  assign s2_go   = s2_valid_r && s3_free;
  assign s2_free = !s2_valid_r || s3_free;
  assign s1_go   = s1_valid_r && s2_free;
  assign s1_free = !s1_valid_r || s2_free;
  assign in_tready = s1_free;
  assign in_acc    = in_tvalid && s1_free;

  // ---------------- raster counters ----------------
  logic [CW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [WCW-1:0]   col_ext;
  logic             acc_res, acc_end;

  assign col_ext = WCW'(col_r);
  assign acc_res = (col_ext >= WCW'(2)) && (row_r >= ROW_W'(2)) &&
                   (col_ext < eff_w) && (row_r < eff_h);
  assign acc_end = (col_ext == eff_w - WCW'(1)) && (row_r == eff_h - ROW_W'(1));

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (col_ext + WCW'(1) >= eff_w) begin
      col_nxt = '0;
      row_nxt = ({1'b0, row_r} + 13'd1 >= {1'b0, eff_h}) ? '0 : row_r + ROW_W'(1);
    end else begin
      col_nxt = col_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ---------------- stage 1: line memory read ----------------
  logic [15:0]      line_mem [MAX_WIDTH];
  logic [15:0]      s1_rd_r;
  pix_t             s1_pix_r;
  logic [CW-1:0]    s1_col_r;
  logic             s1_res_r, s1_end_r;
  logic [CW-1:0]    s1_x_r;
  logic [ROW_W-1:0] s1_y_r;

  always_ff @(posedge clk) begin
    if (s1_go) line_mem[s1_col_r] <= {s1_rd_r[7:0], s1_pix_r};
    if (in_acc) s1_rd_r <= line_mem[col_r];
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r <= in_tdata;
      s1_col_r <= col_r;
      s1_res_r <= acc_res;
      s1_end_r <= acc_end;
      s1_x_r   <= col_r - CW'(1);
      s1_y_r   <= row_r - ROW_W'(1);
    end
  end

  // ---------------- stage 2: 3x3 window ----------------
  pix_t             win_r [3][3];
  logic             s2_end_r;
  logic [CW-1:0]    s2_x_r;
  logic [ROW_W-1:0] s2_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          win_r[i][j] <= '0;
    end else if (s1_go) begin
      for (int i = 0; i < 3; i++) begin
        win_r[i][0] <= win_r[i][1];
        win_r[i][1] <= win_r[i][2];
      end
      win_r[0][2] <= s1_rd_r[15:8];
      win_r[1][2] <= s1_rd_r[7:0];
      win_r[2][2] <= s1_pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_end_r <= s1_end_r;
      s2_x_r   <= s1_x_r;
      s2_y_r   <= s1_y_r;
    end
  end

  // ---------------- stage 3: color select ----------------
  logic [8:0] h_sum, v_sum;
  logic [9:0] e_sum, c_sum;
  pix_t       horiz, vert, edge_avg, corner_avg;
  pix_t       red_nxt, green_nxt, blue_nxt;

  assign h_sum = {1'b0, win_r[1][0]} + {1'b0, win_r[1][2]};
  assign v_sum = {1'b0, win_r[0][1]} + {1'b0, win_r[2][1]};
  assign e_sum = {1'b0, h_sum} + {1'b0, v_sum};
  assign c_sum = 10'(win_r[0][0]) + 10'(win_r[0][2]) + 10'(win_r[2][0]) + 10'(win_r[2][2]);
  assign horiz      = h_sum[8:1];
  assign vert       = v_sum[8:1];
  assign edge_avg   = e_sum[9:2];
  assign corner_avg = c_sum[9:2];

  always_comb begin
    case ({s2_y_r[0], s2_x_r[0]})
      2'b00: begin
        green_nxt = win_r[1][1]; red_nxt = horiz;      blue_nxt = vert;
      end
      2'b01: begin
        red_nxt = win_r[1][1];   green_nxt = edge_avg; blue_nxt = corner_avg;
      end
      2'b10: begin
        blue_nxt = win_r[1][1];  green_nxt = edge_avg; red_nxt = corner_avg;
      end
      default: begin
        green_nxt = win_r[1][1]; red_nxt = vert;       blue_nxt = horiz;
      end
    endcase
  end

  pix_t             s3_red_r, s3_green_r, s3_blue_r;
  logic             s3_end_r;
  logic [CW-1:0]    s3_x_r;
  logic [ROW_W-1:0] s3_y_r;

  always_ff @(posedge clk) begin
    if (s2_go) begin
      s3_red_r   <= red_nxt;
      s3_green_r <= green_nxt;
      s3_blue_r  <= blue_nxt;
      s3_end_r   <= s2_end_r;
      s3_x_r     <= s2_x_r;
      s3_y_r     <= s2_y_r;
    end
  end

  // ---------------- output: luma ----------------
  logic [23:0] luma_sum;

  assign luma_sum = 24'(LUMA_R) * 24'(s3_red_r) +
                    24'(LUMA_G) * 24'(s3_green_r) +
                    24'(LUMA_B) * 24'(s3_blue_r);

  pix_t             out_red_r, out_green_r, out_blue_r, out_grey_r;
  logic             out_end_r;
  logic [CW-1:0]    out_col_r;
  logic [ROW_W-1:0] out_row_r;

  always_ff @(posedge clk) begin
    if (s3_go) begin
      out_red_r   <= s3_red_r;
      out_green_r <= s3_green_r;
      out_blue_r  <= s3_blue_r;
      out_grey_r  <= luma_sum[23:16];
      out_end_r   <= s3_end_r;
      out_col_r   <= s3_x_r;
      out_row_r   <= s3_y_r;
    end
  end

  // ---------------- valid bits ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc)       s1_valid_r <= 1'b1;
      else if (s1_go)   s1_valid_r <= 1'b0;
      // border pixels only move the window
      if (s1_go)        s2_valid_r <= s1_res_r;
      else if (s2_go)   s2_valid_r <= 1'b0;
      if (s2_go)        s3_valid_r <= 1'b1;
      else if (s3_go)   s3_valid_r <= 1'b0;
      if (s3_go)        out_valid_r <= 1'b1;
      else if (o_free)  out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_end_r;

  always_comb begin
    out_tdata = '0;
    out_tdata[PIX_W-1:0]         = out_blue_r;
    out_tdata[2*PIX_W-1:PIX_W]   = out_green_r;
    out_tdata[3*PIX_W-1:2*PIX_W] = out_red_r;
    out_tdata[4*PIX_W-1:3*PIX_W] = out_grey_r;
    out_tdata[OFF_CL +: CW]      = out_col_r;
    out_tdata[OFF_RW +: ROW_W]   = out_row_r;
  end

`ifndef SYNTHESIS
  a_no_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output drains");

  a_interior: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_col_r != '0) && (out_row_r != '0))
    else $error("border pixel reached the output");

  a_mem_port: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && s1_go) |-> (col_r != s1_col_r))
    else $error("line memory read and write collide");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> !$past(s3_go))
    else $error("output register overwritten while stalled");
`endif

endmodule
